/* src/mdim_pkg.sv */
`timescale 1ns / 1ps
package mdim_pkg;

   localparam int FRAC_BITS = 16;

   // field widths
   localparam int CMD_W   = 32;
   localparam int COEF_W  = 32;
   localparam int DEAD_W  = 31;
   localparam int DRIVE_W = 19;
   localparam int CSR_IDX_W = 3;

   // square root: discriminant below 2^66, root below 2^33
   localparam int SQ_W   = COEF_W + 1;
   localparam int DISC_W = 2 * SQ_W;
   // numerator -b +/- s and its magnitude scaled by the fraction
   localparam int NS_W   = SQ_W + 2;
   localparam int NMAG_W = NS_W - 1 + FRAC_BITS;
   localparam int DEN_W  = COEF_W + 1;
   localparam int QS_W   = NMAG_W + 1;

   localparam logic [DRIVE_W-1:0] NEUTRAL_DRIVE = DRIVE_W'(5 * (1 << (FRAC_BITS - 1)));
   localparam logic [DRIVE_W-1:0] FIVE_DRIVE    = DRIVE_W'(5 * (1 << FRAC_BITS));
   localparam logic signed [QS_W-1:0] NEUTRAL_Q = QS_W'(5 * (1 << (FRAC_BITS - 1)));
   localparam logic signed [QS_W-1:0] FIVE_Q    = QS_W'(5 * (1 << FRAC_BITS));
   localparam logic [COEF_W-1:0] GAIN_RESET     = COEF_W'(1 << FRAC_BITS);

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CW_SQUARE_COEF  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CW_LINEAR_COEF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CW_CONST_COEF   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CCW_SQUARE_COEF = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CCW_LINEAR_COEF = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CCW_CONST_COEF  = 3'd7;

   typedef enum logic [1:0] {
      REGION_DEAD = 2'd0,
      REGION_CW   = 2'd1,
      REGION_CCW  = 2'd2,
      REGION_NONE = 2'd3
   } region_type;

   typedef struct packed {
      logic              valid;
      logic [CMD_W-1:0]  target;
      region_type        region;
      logic              fail;
      logic [COEF_W-1:0] coef_a;
      logic [COEF_W-1:0] coef_b;
   } meta_type;

   typedef struct packed {
      meta_type          meta;
      logic [DISC_W-1:0] disc;
      logic [SQ_W+1:0]   rem;
      logic [SQ_W-1:0]   root;
   } sqrt_beat_type;

   typedef struct packed {
      meta_type                   meta;
      logic [DEN_W-1:0]           den;
      logic [1:0][NMAG_W-1:0]     num;
      logic [1:0][DEN_W-1:0]      rem;
      logic [1:0][NMAG_W-1:0]     quo;
      logic [1:0]                 neg;
   } div_beat_type;

endpackage

/* src/mdim_sqrt_cell.sv */
`timescale 1ns / 1ps
module mdim_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  mdim_pkg::sqrt_beat_type beat_in,
   output mdim_pkg::sqrt_beat_type beat_out
);
   import mdim_pkg::*;

   sqrt_beat_type beat_ff;
   sqrt_beat_type beat_in_calc;
   logic [SQ_W+3:0] rem_sh;
   logic [SQ_W+3:0] trial;
   logic [SQ_W+3:0] rem_diff;

   // one root bit per cell: bring down two discriminant bits, try 4q+1
   always_comb begin
      rem_sh   = {beat_in.rem, beat_in.disc[DISC_W-1 -: 2]};
      trial    = {2'b00, beat_in.root, 2'b01};
      rem_diff = rem_sh - trial;
      beat_in_calc      = beat_in;
      beat_in_calc.disc = {beat_in.disc[DISC_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         beat_in_calc.rem  = rem_diff[SQ_W+1:0];
         beat_in_calc.root = {beat_in.root[SQ_W-2:0], 1'b1};
      end else begin
         beat_in_calc.rem  = rem_sh[SQ_W+1:0];
         beat_in_calc.root = {beat_in.root[SQ_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.meta.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in_calc;
      end
   end

   assign beat_out = beat_ff;

endmodule

/* src/mdim_div_cell.sv */
`timescale 1ns / 1ps
module mdim_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  mdim_pkg::div_beat_type beat_in,
   output mdim_pkg::div_beat_type beat_out
);
   import mdim_pkg::*;

   div_beat_type beat_ff;
   div_beat_type beat_in_calc;
   logic [1:0][DEN_W:0] rem_sh;

   // restoring division, one quotient bit per lane per cell
   always_comb begin
      beat_in_calc = beat_in;
      for (int l = 0; l < 2; l++) begin
         rem_sh[l] = {beat_in.rem[l], beat_in.num[l][NMAG_W-1]};
         beat_in_calc.num[l] = {beat_in.num[l][NMAG_W-2:0], 1'b0};
         if (rem_sh[l] >= {1'b0, beat_in.den}) begin
            beat_in_calc.rem[l] = DEN_W'(rem_sh[l] - {1'b0, beat_in.den});
            beat_in_calc.quo[l] = {beat_in.quo[l][NMAG_W-2:0], 1'b1};
         end else begin
            beat_in_calc.rem[l] = rem_sh[l][DEN_W-1:0];
            beat_in_calc.quo[l] = {beat_in.quo[l][NMAG_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.meta.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in_calc;
      end
   end

   assign beat_out = beat_ff;

endmodule

/* src/motor_deadzone_inverse_map.sv */
`timescale 1ns / 1ps
// channel   ports                               direction  beat
// req       req_valid req_stall                 in         command_volts
// rsp       rsp_valid rsp_stall                 out        drive_volts target_rate region
// csr       csr_write_enable csr_index          in         csr_write_data, no handshake
//
// one beat per cycle in and out unless rsp_stall holds the pipe; from accept to rsp_valid a beat passes:
// four front stages, 33 square root cells, one setup stage, 50 divider cells, output register.
// reset (synchronous) empties the pipe and loads gain 1.0, all other csr registers 0.
// the whole pipe holds while a result sits in the output register under rsp_stall;
// req_stall is exactly that condition.
module motor_deadzone_inverse_map (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [mdim_pkg::CMD_W-1:0]   req_command_volts,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mdim_pkg::DRIVE_W-1:0]        rsp_drive_volts,
   output logic signed [mdim_pkg::CMD_W-1:0]   rsp_target_rate,
   output logic [1:0]                          rsp_region,
   input  logic                                csr_write_enable,
   input  logic [mdim_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mdim_pkg::COEF_W-1:0]         csr_write_data
);
   import mdim_pkg::*;

   logic advance;

   logic [COEF_W-1:0] gain_ff, cw_a_ff, cw_b_ff, cw_c_ff, ccw_a_ff, ccw_b_ff, ccw_c_ff;
   logic [DEAD_W-1:0] dead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         dead_ff  <= '0;
         cw_a_ff  <= '0;
         cw_b_ff  <= '0;
         cw_c_ff  <= '0;
         ccw_a_ff <= '0;
         ccw_b_ff <= '0;
         ccw_c_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SPEED_GAIN:      gain_ff  <= csr_write_data;
            CSR_DEAD_THRESHOLD:  dead_ff  <= csr_write_data[DEAD_W-1:0];
            CSR_CW_SQUARE_COEF:  cw_a_ff  <= csr_write_data;
            CSR_CW_LINEAR_COEF:  cw_b_ff  <= csr_write_data;
            CSR_CW_CONST_COEF:   cw_c_ff  <= csr_write_data;
            CSR_CCW_SQUARE_COEF: ccw_a_ff <= csr_write_data;
            CSR_CCW_LINEAR_COEF: ccw_b_ff <= csr_write_data;
            CSR_CCW_CONST_COEF:  ccw_c_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // stage 1: gain product
   logic              v1_ff;
   logic signed [63:0] prod1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
      if (advance) begin
         prod1_ff <= $signed(gain_ff) * req_command_volts;
      end
   end

   // stage 2: floor shift, saturate, dead band, coefficient select
   logic signed [63:0] shifted2;
   logic [CMD_W-1:0]   target2;
   logic signed [32:0] target2_x, dead2_x;
   meta_type           meta2_in, meta2_ff;
   logic [COEF_W-1:0]  c0_2_in, c0_2_ff;

   always_comb begin
      shifted2 = prod1_ff >>> FRAC_BITS;
      if (shifted2 > 64'sh000000007FFFFFFF) begin
         target2 = 32'h7FFFFFFF;
      end else if (shifted2 < 64'shFFFFFFFF80000000) begin
         target2 = 32'h80000000;
      end else begin
         target2 = shifted2[31:0];
      end
      target2_x = $signed({target2[31], target2});
      dead2_x   = $signed({2'b00, dead_ff});
      meta2_in        = '0;
      meta2_in.valid  = v1_ff;
      meta2_in.target = target2;
      if (target2_x > dead2_x) begin
         meta2_in.region = REGION_CW;
         meta2_in.coef_a = cw_a_ff;
         meta2_in.coef_b = cw_b_ff;
         c0_2_in         = cw_c_ff;
      end else if (target2_x < -dead2_x) begin
         meta2_in.region = REGION_CCW;
         meta2_in.coef_a = ccw_a_ff;
         meta2_in.coef_b = ccw_b_ff;
         c0_2_in         = ccw_c_ff;
      end else begin
         meta2_in.region = REGION_DEAD;
         c0_2_in         = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta2_ff.valid <= 1'b0;
      end else if (advance) begin
         meta2_ff <= meta2_in;
      end
      if (advance) begin
         c0_2_ff <= c0_2_in;
      end
   end

   // stage 3: b*b and a*c
   logic signed [32:0] c3;
   logic signed [63:0] bb3_in, bb3_ff;
   logic signed [64:0] ac3_in, ac3_ff;
   meta_type           meta3_ff;

   always_comb begin
      c3     = $signed({c0_2_ff[31], c0_2_ff}) - $signed({meta2_ff.target[31], meta2_ff.target});
      bb3_in = $signed(meta2_ff.coef_b) * $signed(meta2_ff.coef_b);
      ac3_in = $signed(meta2_ff.coef_a) * c3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta3_ff.valid <= 1'b0;
      end else if (advance) begin
         meta3_ff <= meta2_ff;
      end
      if (advance) begin
         bb3_ff <= bb3_in;
         ac3_ff <= ac3_in;
      end
   end

   // stage 4: discriminant
   logic signed [67:0] disc4;
   sqrt_beat_type      sq_chain [0:SQ_W];
   sqrt_beat_type      sq4_in;

   always_comb begin
      disc4 = $signed({4'b0000, bb3_ff}) - $signed({ac3_ff[64], ac3_ff, 2'b00});
      sq4_in      = '0;
      sq4_in.meta = meta3_ff;
      sq4_in.meta.fail = (meta3_ff.coef_a == '0) || disc4[67];
      if (!sq4_in.meta.fail && meta3_ff.region != REGION_DEAD) begin
         sq4_in.disc = disc4[DISC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_chain[0].meta.valid <= 1'b0;
      end else if (advance) begin
         sq_chain[0] <= sq4_in;
      end
   end

   for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
      mdim_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .beat_in  (sq_chain[i]),
         .beat_out (sq_chain[i+1])
      );
   end

   // stage 5: numerators -b +/- s and the divisor 2|a|
   logic signed [NS_W-1:0] nb5, s5;
   logic signed [NS_W-1:0] n5 [2];
   logic [NS_W-1:0]        nmag5 [2];
   logic [COEF_W-1:0]      amag5;
   div_beat_type           dv_chain [0:NMAG_W];
   div_beat_type           dv5_in;

   always_comb begin
      nb5   = -$signed({{(NS_W-COEF_W){sq_chain[SQ_W].meta.coef_b[COEF_W-1]}},
                        sq_chain[SQ_W].meta.coef_b});
      s5    = $signed({2'b00, sq_chain[SQ_W].root});
      n5[0] = nb5 + s5;
      n5[1] = nb5 - s5;
      amag5 = sq_chain[SQ_W].meta.coef_a[COEF_W-1] ? (~sq_chain[SQ_W].meta.coef_a + 1'b1)
                                                   : sq_chain[SQ_W].meta.coef_a;
      dv5_in      = '0;
      dv5_in.meta = sq_chain[SQ_W].meta;
      dv5_in.den  = {amag5, 1'b0};
      for (int l = 0; l < 2; l++) begin
         nmag5[l]         = n5[l][NS_W-1] ? NS_W'(-n5[l]) : NS_W'(n5[l]);
         dv5_in.num[l]    = {nmag5[l][NS_W-2:0], {FRAC_BITS{1'b0}}};
         dv5_in.neg[l]    = n5[l][NS_W-1] ^ sq_chain[SQ_W].meta.coef_a[COEF_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_chain[0].meta.valid <= 1'b0;
      end else if (advance) begin
         dv_chain[0] <= dv5_in;
      end
   end

   for (genvar i = 0; i < NMAG_W; i++) begin : g_div
      mdim_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .beat_in  (dv_chain[i]),
         .beat_out (dv_chain[i+1])
      );
   end

   // output: sign, range check, pick the smaller valid root
   div_beat_type           dv_last;
   logic signed [QS_W-1:0] q6 [2];
   logic signed [QS_W-1:0] lo6, hi6, root6;
   logic [1:0]             ok6;
   region_type             region6;
   logic [DRIVE_W-1:0]     drive6;
   logic [DRIVE_W-1:0]     drive_ff;
   logic [CMD_W-1:0]       target_ff;
   region_type             region_ff;

   always_comb begin
      dv_last = dv_chain[NMAG_W];
      if (dv_last.meta.region == REGION_CW) begin
         lo6 = NEUTRAL_Q;
         hi6 = FIVE_Q;
      end else begin
         lo6 = '0;
         hi6 = NEUTRAL_Q;
      end
      for (int l = 0; l < 2; l++) begin
         q6[l]  = dv_last.neg[l] ? -$signed({1'b0, dv_last.quo[l]})
                                 : $signed({1'b0, dv_last.quo[l]});
         ok6[l] = (q6[l] >= lo6) && (q6[l] <= hi6);
      end
      if (ok6[0] && ok6[1]) begin
         root6 = (q6[0] < q6[1]) ? q6[0] : q6[1];
      end else if (ok6[0]) begin
         root6 = q6[0];
      end else begin
         root6 = q6[1];
      end
      if (dv_last.meta.region == REGION_DEAD) begin
         region6 = REGION_DEAD;
         drive6  = NEUTRAL_DRIVE;
      end else if (dv_last.meta.fail || ok6 == 2'b00) begin
         region6 = REGION_NONE;
         drive6  = NEUTRAL_DRIVE;
      end else begin
         region6 = dv_last.meta.region;
         drive6  = root6[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_last.meta.valid;
      end
      if (advance) begin
         drive_ff  <= drive6;
         target_ff <= dv_last.meta.target;
         region_ff <= region6;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_volts = drive_ff;
   assign rsp_target_rate = $signed(target_ff);
   assign rsp_region      = region_ff;

endmodule

/* src/mdim_checker.sv */
`timescale 1ns / 1ps
module mdim_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [mdim_pkg::DRIVE_W-1:0]      rsp_drive_volts,
   input logic [1:0]                        rsp_region
);
   import mdim_pkg::*;

   // a held result beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped under stall");

   // input only holds back while the output register is blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a blocked rsp beat");

   // dead band and no-root beats carry the neutral drive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_region == REGION_DEAD || rsp_region == REGION_NONE)
      |-> rsp_drive_volts == NEUTRAL_DRIVE)
      else $error("non-root beat with drive other than neutral");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive_volts <= FIVE_DRIVE)
      else $error("drive above full scale");

endmodule

bind motor_deadzone_inverse_map mdim_checker u_mdim_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_drive_volts (rsp_drive_volts),
   .rsp_region      (rsp_region)
);

/* test/mdim_checker.sv */
`timescale 1ns / 1ps
module mdim_scoreboard (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [mdim_pkg::CMD_W-1:0] req_command_volts,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [mdim_pkg::DRIVE_W-1:0]      rsp_drive_volts,
   input  logic signed [mdim_pkg::CMD_W-1:0] rsp_target_rate,
   input  logic [1:0]                        rsp_region,
   input  logic                              csr_write_enable,
   input  logic [mdim_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mdim_pkg::COEF_W-1:0]       csr_write_data,
   output int                                errors,
   output int                                pending
);
   import mdim_pkg::*;

   typedef struct packed {
      logic [DRIVE_W-1:0]      drive;
      logic signed [CMD_W-1:0] rate;
      region_type              region;
   } drive_sample_type;

   logic signed [COEF_W-1:0] gain;
   logic [DEAD_W-1:0]        dead_band;
   logic signed [COEF_W-1:0] cw_a, cw_b, cw_c, ccw_a, ccw_b, ccw_c;
   drive_sample_type         expected_q[$];

   localparam longint NEUTRAL_V = 5 * (longint'(1) << (FRAC_BITS - 1));
   localparam longint FIVE_V    = 5 * (longint'(1) << FRAC_BITS);

   // roots of a*v^2 + b*v + c = 0 inside [lo, hi], smaller one wins
   function automatic bit solve_drive(input longint a, input longint b, input longint c,
                                      input longint lo, input longint hi,
                                      output longint v);
      logic signed [127:0] aw, bw, cw, disc, tw;
      logic [63:0]         t;
      longint              s, den, r1, r2;
      bit                  ok1, ok2;
      v = 0;
      if (a == 0) return 0;
      aw = a;
      bw = b;
      cw = c;
      disc = bw * bw - 4 * aw * cw;
      if (disc < 0) return 0;
      s = 0;
      for (int k = 40; k >= 0; k--) begin
         t = s | (64'd1 << k);
         tw = {64'd0, t};
         if (tw * tw <= disc) s = t;
      end
      den = 2 * a;
      r1 = ((-b + s) * (longint'(1) << FRAC_BITS)) / den;
      r2 = ((-b - s) * (longint'(1) << FRAC_BITS)) / den;
      ok1 = r1 >= lo && r1 <= hi;
      ok2 = r2 >= lo && r2 <= hi;
      if (ok1 && ok2) v = r1 < r2 ? r1 : r2;
      else if (ok1) v = r1;
      else if (ok2) v = r2;
      else return 0;
      return 1;
   endfunction

   function automatic drive_sample_type map_command(input logic signed [CMD_W-1:0] cmd);
      drive_sample_type res;
      longint           prod, rate, dead, drive, root;
      prod = longint'(gain) * longint'(cmd);
      rate = prod >>> FRAC_BITS;
      if (rate > 64'sh7FFFFFFF) rate = 64'sh7FFFFFFF;
      if (rate < -64'sh80000000) rate = -64'sh80000000;
      dead = longint'({1'b0, dead_band});
      drive = NEUTRAL_V;
      res.region = REGION_DEAD;
      if (rate > dead) begin
         if (solve_drive(cw_a, cw_b, longint'(cw_c) - rate, NEUTRAL_V, FIVE_V, root)) begin
            drive = root;
            res.region = REGION_CW;
         end else begin
            res.region = REGION_NONE;
         end
      end else if (rate < -dead) begin
         if (solve_drive(ccw_a, ccw_b, longint'(ccw_c) - rate, 0, NEUTRAL_V, root)) begin
            drive = root;
            res.region = REGION_CCW;
         end else begin
            res.region = REGION_NONE;
         end
      end
      if (drive < 0) drive = 0;
      if (drive > FIVE_V) drive = FIVE_V;
      res.drive = drive[DRIVE_W-1:0];
      res.rate = rate[CMD_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      drive_sample_type want;
      if (reset) begin
         gain <= GAIN_RESET;
         dead_band <= '0;
         cw_a <= '0; cw_b <= '0; cw_c <= '0;
         ccw_a <= '0; ccw_b <= '0; ccw_c <= '0;
         expected_q.delete();
         pending <= 0;
         errors = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SPEED_GAIN:      gain <= csr_write_data;
               CSR_DEAD_THRESHOLD:  dead_band <= csr_write_data[DEAD_W-1:0];
               CSR_CW_SQUARE_COEF:  cw_a <= csr_write_data;
               CSR_CW_LINEAR_COEF:  cw_b <= csr_write_data;
               CSR_CW_CONST_COEF:   cw_c <= csr_write_data;
               CSR_CCW_SQUARE_COEF: ccw_a <= csr_write_data;
               CSR_CCW_LINEAR_COEF: ccw_b <= csr_write_data;
               CSR_CCW_CONST_COEF:  ccw_c <= csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_q.push_back(map_command(req_command_volts));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected beat drive=%0d rate=%0d region=%0d", $time,
                        rsp_drive_volts, rsp_target_rate, rsp_region);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_drive_volts !== want.drive) begin
                  $display("%0t: drive_volts expected %0d actual %0d", $time,
                           want.drive, rsp_drive_volts);
                  errors++;
               end
               if (rsp_target_rate !== want.rate) begin
                  $display("%0t: target_rate expected %0d actual %0d", $time,
                           want.rate, rsp_target_rate);
                  errors++;
               end
               if (rsp_region !== want.region) begin
                  $display("%0t: region expected %0d actual %0d", $time,
                           want.region, rsp_region);
                  errors++;
               end
            end
         end
         pending <= expected_q.size();
      end
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
   import mdim_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   // nice calibrations: cw rate = (v - 2.5)(v + 2.5), ccw rate = -(v - 2.5)^2
   localparam logic [31:0] ONE_Q   = 32'd65536;
   localparam logic [31:0] C625_Q  = 32'd409600;
   localparam logic [31:0] FIVE_Q  = 32'd327680;

   logic                     clock = 0;
   logic                     reset;
   logic                     req_valid, req_stall;
   logic signed [CMD_W-1:0]  req_command_volts;
   logic                     rsp_valid, rsp_stall;
   logic [DRIVE_W-1:0]       rsp_drive_volts;
   logic signed [CMD_W-1:0]  rsp_target_rate;
   logic [1:0]               rsp_region;
   logic                     csr_write_enable;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [COEF_W-1:0]        csr_write_data;
   int                       errors, pending, quiet_cycles;
   bit                       tx_gaps, rx_gaps, rx_hold;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   motor_deadzone_inverse_map u_dut (.*);

   mdim_scoreboard u_check (.*);

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic load_map(input logic [31:0] g, input logic [31:0] dz,
                           input logic [31:0] a1, input logic [31:0] b1, input logic [31:0] c1,
                           input logic [31:0] a2, input logic [31:0] b2, input logic [31:0] c2);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      write_reg(CSR_SPEED_GAIN, g);
      write_reg(CSR_DEAD_THRESHOLD, dz);
      write_reg(CSR_CW_SQUARE_COEF, a1);
      write_reg(CSR_CW_LINEAR_COEF, b1);
      write_reg(CSR_CW_CONST_COEF, c1);
      write_reg(CSR_CCW_SQUARE_COEF, a2);
      write_reg(CSR_CCW_LINEAR_COEF, b2);
      write_reg(CSR_CCW_CONST_COEF, c2);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   task automatic send_command(input logic [31:0] cmd);
      int gap;
      gap = tx_gaps ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_command_volts <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_command();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return $urandom_range(0, 50 * 65536) - 25 * 65536;
         3: return $urandom_range(0, 2000) - 1000;
         4: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                        : 32'h80000000 + $urandom_range(0, 3);
         default: return $urandom_range(0, 8 * 65536) - 4 * 65536;
      endcase
   endfunction

   function automatic logic [31:0] small_coef(input int span);
      return $urandom_range(0, 2 * span * 65536) - span * 65536;
   endfunction

   task automatic random_run(input int n);
      for (int k = 0; k < n; k++) begin
         if (k % 60 == 0) begin
            tx_gaps = $urandom_range(0, 3) != 0;
            rx_gaps = $urandom_range(0, 3) != 0;
         end
         send_command(pick_command());
      end
      req_valid <= 0;
      @(posedge clock);
   endtask

   // receiver: random stalls per beat, plus an occasional long hold-off
   initial begin
      int n;
      rsp_stall <= 0;
      @(negedge reset);
      forever begin
         if (rx_hold) begin
            rsp_stall <= 1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_hold = 0;
         end else begin
            n = rx_gaps ? $urandom_range(0, 4) : 0;
            if (n != 0) begin
               rsp_stall <= 1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] directed[] = '{32'd0, 32'd1, -32'sd1, 32'd1228800, 32'd1228801,
                                  32'd65536, 32'd409600, -32'sd65536, -32'sd409600,
                                  -32'sd409601, -32'sd163840, 32'h7FFFFFFF, 32'h80000000,
                                  32'd2, -32'sd2, 32'h55555555, 32'hAAAAAAAA, 32'd300000,
                                  -32'sd300000, 32'd1000};
      reset <= 1;
      req_valid <= 0;
      req_command_volts <= 0;
      csr_write_enable <= 0;
      csr_index <= CSR_SPEED_GAIN;
      csr_write_data <= 0;
      tx_gaps = 1;
      rx_gaps = 1;
      rx_hold = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset values: zero leading coefficients everywhere
      for (int k = 0; k < 5; k++) send_command(directed[k]);
      req_valid <= 0;
      @(posedge clock);

      load_map(ONE_Q, 0, ONE_Q, 0, -C625_Q, -ONE_Q, FIVE_Q, -C625_Q);
      foreach (directed[k]) send_command(directed[k]);
      req_valid <= 0;
      @(posedge clock);
      random_run(230);

      load_map(ONE_Q >> 1, 2 * ONE_Q, ONE_Q, 0, -C625_Q, -ONE_Q, FIVE_Q, -C625_Q);
      rx_hold = 1;
      random_run(250);

      load_map(small_coef(4), $urandom_range(0, 65536), small_coef(4), small_coef(16),
               small_coef(16), small_coef(4), small_coef(16), small_coef(16));
      random_run(250);

      load_map($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom);
      random_run(200);

      load_map(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      random_run(150);

      load_map(32'h80000000, 0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h80000000);
      random_run(150);

      load_map(-ONE_Q, 32'd1000, ONE_Q, 0, -C625_Q, -ONE_Q, FIVE_Q, -C625_Q);
      rx_hold = 1;
      random_run(250);

      load_map(small_coef(2), $urandom_range(0, 4096), small_coef(2), small_coef(8),
               small_coef(8), small_coef(2), small_coef(8), small_coef(8));
      random_run(300);

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
